FILE: design/arln_pkg.sv
`timescale 1ns / 1ps

package arln_pkg;

    localparam int RAW_W    = 16;
    localparam int OFFSET_W = 8;
    localparam int COUNT_W  = 15;
    localparam int LEVEL_W  = 16;
    localparam int CFG_W    = 15;
    localparam int STEP_W   = 4;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]  PEAK_RESET   = 15'd100;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 15'd32767;
    localparam logic [STEP_W-1:0]   LAST_STEP    = 4'd15;

    // Configuration register indexes.
    localparam logic REG_SIGNAL_OFFSET = 1'b0;
    localparam logic REG_INITIAL_PEAK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } seq_state_t;

    typedef struct packed {
        logic                 load;
        logic [COUNT_W-1:0]   value;
    } peak_load_t;

    typedef struct packed {
        logic                 valid;
        logic [LEVEL_W-1:0]   level;
        logic [COUNT_W-1:0]   count;
        logic [COUNT_W-1:0]   peak;
    } result_t;

endpackage

FILE: design/arln_divstep.sv
`timescale 1ns / 1ps

module arln_divstep (
    input  logic [arln_pkg::COUNT_W-1:0] rem_in,
    input  logic                         bit_in,
    input  logic [arln_pkg::COUNT_W-1:0] divisor,
    output logic [arln_pkg::COUNT_W-1:0] rem_out,
    output logic                         q_bit
);
    import arln_pkg::*;

    logic [COUNT_W:0] rem_shift;
    logic [COUNT_W:0] diff;

    assign rem_shift = {rem_in, bit_in};
    assign diff      = rem_shift - {1'b0, divisor};
    assign q_bit     = (rem_shift >= {1'b0, divisor});
    // The remainder stays below the divisor, so the top bit is always zero.
    assign rem_out   = q_bit ? diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];

endmodule

FILE: design/arln_seq.sv
`timescale 1ns / 1ps

module arln_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [arln_pkg::RAW_W-1:0]    raw_signal,
    input  logic [arln_pkg::OFFSET_W-1:0] signal_offset,
    input  arln_pkg::peak_load_t          peak_load,
    input  logic                          out_free,
    output arln_pkg::result_t             result
);
    import arln_pkg::*;

    localparam int DVD_W = COUNT_W + LEVEL_W;

    seq_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] peak_reg, peak_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0] dvd_reg, dvd_next;

    logic [RAW_W:0]     diff;
    logic [COUNT_W-1:0] count_calc;
    logic [COUNT_W-1:0] peak_calc;
    logic [DVD_W-1:0]   dividend;
    logic [COUNT_W-1:0] step_rem;
    logic               step_q;
    logic               last_step;

    // Offset removal, floor at zero and saturation.
    assign diff = {1'b0, raw_reg} - {{(RAW_W-OFFSET_W+1){1'b0}}, signal_offset};
    always_comb begin
        if (raw_reg <= {{(RAW_W-OFFSET_W){1'b0}}, signal_offset}) begin
            count_calc = '0;
        end else if (diff[RAW_W-1:0] > {1'b0, COUNT_MAX}) begin
            count_calc = COUNT_MAX;
        end else begin
            count_calc = diff[COUNT_W-1:0];
        end
    end

    assign peak_calc = (count_calc > peak_reg) ? count_calc : peak_reg;

    // count * 65535 as (count << 16) - count.
    assign dividend = {count_calc, {LEVEL_W{1'b0}}}
                    - {{LEVEL_W{1'b0}}, count_calc};

    arln_divstep u_divstep (
        .rem_in  (rem_reg),
        .bit_in  (dvd_reg[LEVEL_W-1]),
        .divisor (peak_reg),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    assign last_step = (step_reg == LAST_STEP);
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        raw_next   = raw_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        result     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (peak_load.load) begin
                    peak_next = peak_load.value;
                end
                if (in_valid) begin
                    raw_next   = raw_signal;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                count_next = count_calc;
                peak_next  = peak_calc;
                rem_next   = dividend[DVD_W-1:LEVEL_W];
                dvd_next   = dividend[LEVEL_W-1:0];
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // The final step waits until the output register can take it.
                if (!last_step || out_free) begin
                    rem_next  = step_rem;
                    dvd_next  = {dvd_reg[LEVEL_W-2:0], step_q};
                    step_next = step_reg + 1'b1;
                end
                if (last_step && out_free) begin
                    result.valid = 1'b1;
                    result.level = {dvd_reg[LEVEL_W-2:0], step_q};
                    result.count = count_reg;
                    result.peak  = peak_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            peak_reg  <= PEAK_RESET;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            peak_reg  <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg   <= raw_next;
        count_reg <= count_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
    end

endmodule

FILE: design/auto_ranging_level_normalizer_unit.sv
`timescale 1ns / 1ps

// Auto-ranging level normalizer.
// Input stream (s_*): one raw 16-bit sensor count per request. The block
// subtracts signal_offset, floors at zero, saturates at 32767, raises the
// running peak if the count exceeds it, and returns one result request on
// the output stream (m_*) with count*65535/peak, the count and the peak.
// Registers are written through cfg_we/cfg_index/cfg_wdata: index 0 is
// signal_offset, index 1 is initial_peak, whose write also restarts the
// running peak at that value. Write them only while the block is idle.
// Each request first passes a load step that corrects the count and updates
// the peak, then a restoring divider that produces the 16-bit quotient one
// bit per cycle, the last bit only when the output register is free, through
// one shared subtract-and-compare unit. One request is in work at a time; a
// new one is taken only after the result is passed on. s_tready is high while
// the sequencer is idle, also while a result still waits in the output
// register. If the receiver stalls, the last divider step waits until the
// output register is free. Reset (aresetn low, synchronous) restores the
// offset to 5 and the peak to 100 and empties the output register.
module auto_ranging_level_normalizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] raw_signal
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] normalized_level, [30:16] clamped_count,
                                    // [45:31] current_peak, [47:46] zero
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata
);
    import arln_pkg::*;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [47:0]         m_tdata_reg, m_tdata_next;
    peak_load_t          peak_load;
    result_t             result;
    logic                out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    assign peak_load.load  = cfg_we && (cfg_index == REG_INITIAL_PEAK);
    assign peak_load.value = cfg_wdata[COUNT_W-1:0];

    always_comb begin
        offset_next = offset_reg;
        if (cfg_we && (cfg_index == REG_SIGNAL_OFFSET)) begin
            offset_next = cfg_wdata[OFFSET_W-1:0];
        end
    end

    arln_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .raw_signal    (s_tdata),
        .signal_offset (offset_reg),
        .peak_load     (peak_load),
        .out_free      (out_free),
        .result        (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (result.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, result.peak, result.count, result.level};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= OFFSET_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            offset_reg   <= offset_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
